[rtl/dmflb_pkg.sv]
// ----------------------------------------------------------------------------
// dmflb_pkg
// Shared types and constants for the dual-mode FIFO/LIFO buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package dmflb_pkg;

  localparam int DEPTH_DEFAULT     = 1024;
  localparam int WORD_BITS_DEFAULT = 32;

  // Configuration register widths and indexes
  localparam int CAP_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1024;

  // Order modes
  localparam logic LIFO = 1'b0;
  localparam logic FIFO = 1'b1;

  // Operations
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Result metadata carried alongside the word
  typedef struct packed {
    logic [1:0]       status;
    logic [CAP_W-1:0] occupancy;
  } res_meta_t;

  // Control stage output: one beat of result, word still in the RAM read register
  typedef struct packed {
    logic      valid;
    logic      pop_ok;
    res_meta_t meta;
  } res_t;

endpackage

`default_nettype wire

[rtl/dmflb_mem.sv]
// ----------------------------------------------------------------------------
// dmflb_mem
// Single-port word store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmflb_mem #(
  parameter int DEPTH     = dmflb_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = dmflb_pkg::WORD_BITS_DEFAULT,
  parameter int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        addr,
  input  wire logic [WORD_BITS-1:0] wdata,
  output logic      [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[rtl/dmflb_ctrl.sv]
// ----------------------------------------------------------------------------
// dmflb_ctrl
// Configuration registers, index/count bookkeeping and result status.
// ----------------------------------------------------------------------------
`default_nettype none

module dmflb_ctrl #(
  parameter int DEPTH = dmflb_pkg::DEPTH_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            accept,
  input  wire logic                            func,
  input  wire logic                            cfg_we,
  input  wire logic [dmflb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dmflb_pkg::CFG_W-1:0]     cfg_data,
  output logic                                 mem_we,
  output logic                                 mem_re,
  output logic      [AW-1:0]                   mem_addr,
  output dmflb_pkg::res_t                      res
);

  localparam int CAP_W = dmflb_pkg::CAP_W;
  localparam int LW    = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  logic             order_mode;
  logic [CAP_W-1:0] capacity_in_use;
  logic [LW-1:0]    write_index, write_index_next;
  logic [LW-1:0]    read_index, read_index_next;
  logic [CAP_W-1:0] entry_count, entry_count_next;

  logic [LW-1:0]    cap;
  logic [LW-1:0]    cap_raw;
  logic [LW-1:0]    count_l;
  logic [LW-1:0]    w_cur, w_inc, w_dec, r_cur, r_inc;
  logic [LW-1:0]    addr_l;
  logic             full, empty;
  logic             op_ok;
  logic [1:0]       status_next;

  // Clamp capacity to 1..DEPTH
  always_comb begin
    cap_raw = LW'(capacity_in_use);
    if (capacity_in_use == '0) begin
      cap = LW'(1);
    end else if (cap_raw > DEPTH_L) begin
      cap = DEPTH_L;
    end else begin
      cap = cap_raw;
    end
  end

  always_comb begin
    count_l = LW'(entry_count);
    full    = (count_l >= cap);
    empty   = (entry_count == '0);

    w_cur = (write_index >= cap) ? '0 : write_index;
    w_inc = w_cur + LW'(1);
    if (order_mode == dmflb_pkg::FIFO && w_inc >= cap) begin
      w_inc = '0;
    end
    w_dec = (write_index == '0) ? '0 : write_index - LW'(1);

    r_cur = (read_index >= cap) ? '0 : read_index;
    r_inc = r_cur + LW'(1);
    if (r_inc >= cap) begin
      r_inc = '0;
    end

    write_index_next = write_index;
    read_index_next  = read_index;
    entry_count_next = entry_count;
    addr_l           = w_cur;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    op_ok            = 1'b0;
    status_next      = dmflb_pkg::STATUS_OK;

    if (func == dmflb_pkg::FUNC_PUSH) begin
      if (full) begin
        status_next = dmflb_pkg::STATUS_FULL;
      end else begin
        mem_we           = accept;
        write_index_next = w_inc;
        entry_count_next = entry_count + CAP_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = dmflb_pkg::STATUS_EMPTY;
      end else if (order_mode == dmflb_pkg::LIFO) begin
        op_ok            = 1'b1;
        mem_re           = accept;
        addr_l           = w_dec;
        write_index_next = w_dec;
        entry_count_next = entry_count - CAP_W'(1);
      end else begin
        op_ok            = 1'b1;
        mem_re           = accept;
        addr_l           = r_cur;
        read_index_next  = r_inc;
        entry_count_next = entry_count - CAP_W'(1);
      end
    end
    mem_addr = addr_l[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode      <= dmflb_pkg::FIFO;
      capacity_in_use <= dmflb_pkg::CAPACITY_RESET;
      write_index     <= '0;
      read_index      <= '0;
      entry_count     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dmflb_pkg::REG_ORDER_MODE: begin
          order_mode  <= cfg_data[0];
          write_index <= '0;
          read_index  <= '0;
          entry_count <= '0;
        end
        dmflb_pkg::REG_CAPACITY: begin
          capacity_in_use <= cfg_data;
          write_index     <= '0;
          read_index      <= '0;
          entry_count     <= '0;
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end else if (accept) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= accept;
    end
    if (accept) begin
      res.pop_ok         <= op_ok;
      res.meta.status    <= status_next;
      res.meta.occupancy <= entry_count_next;
    end
  end

endmodule

`default_nettype wire

[rtl/dmflb_outq.sv]
// ----------------------------------------------------------------------------
// dmflb_outq
// Two-entry result queue that decouples the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module dmflb_outq #(
  parameter int WORD_BITS = dmflb_pkg::WORD_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire logic [WORD_BITS-1:0]   push_word,
  input  wire dmflb_pkg::res_meta_t   push_meta,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic      [WORD_BITS-1:0]   out_word,
  output dmflb_pkg::res_meta_t        out_meta,
  output logic      [1:0]             count
);

  logic [WORD_BITS-1:0]  word_q [2];
  dmflb_pkg::res_meta_t  meta_q [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic                  pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_word  = word_q[rd_ptr];
  assign out_meta  = meta_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word_q[wr_ptr] <= push_word;
      meta_q[wr_ptr] <= push_meta;
    end
  end

endmodule

`default_nettype wire

[rtl/dual_mode_fifo_lifo_buffer.sv]
// A push or pop can be accepted every cycle while in_ready is high; its result
// is registered alongside the registered read port of the word store and is
// then offered to the receiver through a register in the result
// queue. The result queue lets the block keep taking input while a finished
// result waits, so up to two results sit in the block before input stalls.
// Rejected operations return a status and leave the buffer untouched.
// Writing either configuration register empties the buffer; stored words are
// not cleared. No clearing pass after reset.
// ----------------------------------------------------------------------------
// dual_mode_fifo_lifo_buffer
// Word buffer that runs as a circular FIFO ring or a LIFO stack.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_mode_fifo_lifo_buffer #(
  parameter int DEPTH     = dmflb_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = dmflb_pkg::WORD_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            func,
  input  wire logic signed [WORD_BITS-1:0]     push_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [WORD_BITS-1:0]          pop_value,
  output logic      [1:0]                      status,
  output logic      [dmflb_pkg::CAP_W-1:0]     occupancy,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dmflb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dmflb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  accept;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [WORD_BITS-1:0]  mem_rdata;
  logic [WORD_BITS-1:0]  res_word;
  dmflb_pkg::res_t       res;
  dmflb_pkg::res_meta_t  out_meta;
  logic [WORD_BITS-1:0]  out_word;
  logic [1:0]            q_count;
  logic [1:0]            in_flight;
  logic [1:0]            in_flight_after;

  assign cfg_ready = 1'b1;

  // Credit check: at most two results in flight once this beat's pop is done
  assign in_flight       = q_count + {1'b0, res.valid};
  assign in_flight_after = in_flight - {1'b0, out_valid && out_ready};
  assign in_ready        = (in_flight_after < 2'd2);
  assign accept          = in_valid && in_ready;

  dmflb_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .func      (func),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .res       (res)
  );

  dmflb_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (push_value),
    .rdata (mem_rdata)
  );

  // Zero the word on pushes and rejected pops
  assign res_word = res.pop_ok ? mem_rdata : '0;

  dmflb_outq #(
    .WORD_BITS (WORD_BITS)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res.valid),
    .push_word (res_word),
    .push_meta (res.meta),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_meta  (out_meta),
    .count     (q_count)
  );

  assign pop_value = out_word;
  assign status    = out_meta.status;
  assign occupancy = out_meta.occupancy;

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res.valid && q_count == 2'd2 |-> out_ready)
    else $error("result queue overflow");

  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res.valid)
    else $error("accepted beat produced no result");

  a_empty_has_no_entries: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dmflb_pkg::STATUS_EMPTY |-> occupancy == '0 && pop_value == '0)
    else $error("empty status with entries held or nonzero word");

  a_full_has_entries: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dmflb_pkg::STATUS_FULL |-> occupancy != '0 && pop_value == '0)
    else $error("full status with no entries or nonzero word");

endmodule

`default_nettype wire

[verif/dual_mode_fifo_lifo_buffer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_mode_fifo_lifo_buffer_test
// Self-checking bench for the FIFO/LIFO word buffer. Drives push and pop
// beats and configuration writes over valid/ready. Predicts every result from
// its own model of the ring, the stack and the capacity rules, then compares
// the results in order. Sender gaps and receiver stalls vary per phase.
// ----------------------------------------------------------------------------
module dual_mode_fifo_lifo_buffer_test;
  import dmflb_pkg::*;

  localparam int SLOTS      = DEPTH_DEFAULT;
  localparam int WB         = WORD_BITS_DEFAULT;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_GAP    = 40;

  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [WB-1:0] word;
    logic [1:0]           code;
    logic [CAP_W-1:0]     held;
  } buf_result_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    func;
  logic signed [WB-1:0]    push_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [WB-1:0]    pop_value;
  logic [1:0]              status;
  logic [CAP_W-1:0]        occupancy;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  dual_mode_fifo_lifo_buffer dut (.*);

  always #10 clk = ~clk;

  // buffer model state
  logic [WB-1:0]    slot_mem [SLOTS];
  int               wr_pos;
  int               rd_pos;
  int               held_count;
  logic             order_sel;
  logic [CAP_W-1:0] cap_reg;

  buf_result_t expected_results[$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;

  function automatic int live_capacity();
    if (cap_reg == '0) return 1;
    if (int'(cap_reg) > SLOTS) return SLOTS;
    return int'(cap_reg);
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
    if (idx == REG_ORDER_MODE || idx == REG_CAPACITY) begin
      if (idx == REG_ORDER_MODE) order_sel = data[0];
      else cap_reg = data[CAP_W-1:0];
      wr_pos = 0;
      rd_pos = 0;
      held_count = 0;
    end
  endfunction

  function automatic buf_result_t predict_buffer_op(input logic op,
                                                    input logic [WB-1:0] word);
    buf_result_t r;
    int lim;
    int w;
    r.word = '0;
    r.code = STATUS_OK;
    lim = live_capacity();
    if (op == FUNC_PUSH) begin
      if (held_count >= lim) begin
        r.code = STATUS_FULL;
      end else begin
        w = (wr_pos >= lim) ? 0 : wr_pos;
        slot_mem[w % SLOTS] = word;
        w++;
        if (order_sel == FIFO && w >= lim) w = 0;
        wr_pos = w;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.code = STATUS_EMPTY;
    end else if (order_sel == LIFO) begin
      w = (wr_pos == 0) ? 0 : wr_pos - 1;
      r.word = slot_mem[w % SLOTS];
      wr_pos = w;
      held_count--;
    end else begin
      w = (rd_pos >= lim) ? 0 : rd_pos;
      r.word = slot_mem[w % SLOTS];
      w++;
      if (w >= lim) w = 0;
      rd_pos = w;
      held_count--;
    end
    r.held = held_count[CAP_W-1:0];
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input longint want,
                                        input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
               $realtime, what, want, want, got, got);
  endfunction

  // compare results, then record config and predictions for this edge
  always @(posedge clk) begin : monitor
    buf_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result, pop_value", 0, pop_value);
        end else begin
          want = expected_results.pop_front();
          if (pop_value !== want.word) flag_mismatch("pop_value", want.word, pop_value);
          if (status !== want.code) flag_mismatch("status", want.code, status);
          if (occupancy !== want.held) flag_mismatch("occupancy", want.held, occupancy);
        end
      end
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) expected_results.push_back(predict_buffer_op(func, push_value));
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic set_idling(input int sel);
    case (sel % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
  endtask

  task automatic send_op(input logic op, input logic [WB-1:0] word);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= op;
    push_value <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold input until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int count, input int push_pct);
    for (int i = 0; i < count; i++)
      send_op(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP, $urandom);
  endtask

  // reset state is a ring of full size
  task automatic test_fifo_extremes();
    set_idling(0);
    send_op(FUNC_POP, $urandom);
    send_op(FUNC_PUSH, 32'h8000_0000);
    send_op(FUNC_PUSH, 32'h7FFF_FFFF);
    send_op(FUNC_PUSH, 32'h0000_0000);
    send_op(FUNC_PUSH, 32'hFFFF_FFFF);
    repeat (5) send_op(FUNC_POP, $urandom);
  endtask

  // capacity zero behaves as a single slot
  task automatic test_capacity_zero();
    set_idling(3);
    write_register(REG_CAPACITY, '0);
    send_op(FUNC_PUSH, 32'h5555_5555);
    send_op(FUNC_PUSH, 32'hAAAA_AAAA);
    send_op(FUNC_POP, $urandom);
    send_op(FUNC_POP, $urandom);
  endtask

  task automatic test_stack_order();
    set_idling(2);
    // upper data bits must be masked off the mode register
    write_register(REG_ORDER_MODE, {10'h3FF, LIFO});
    write_register(REG_CAPACITY, 11'd3);
    send_op(FUNC_PUSH, 32'h1234_5678);
    send_op(FUNC_PUSH, 32'h8765_4321);
    send_op(FUNC_PUSH, 32'hDEAD_BEEF);
    send_op(FUNC_PUSH, 32'h0BAD_F00D);
    send_op(FUNC_POP, $urandom);
    send_op(FUNC_POP, $urandom);
    send_op(FUNC_PUSH, 32'hCAFE_0001);
    repeat (3) send_op(FUNC_POP, $urandom);
  endtask

  // spare indexes must leave contents alone
  task automatic test_spare_index();
    set_idling(1);
    send_op(FUNC_PUSH, $urandom);
    send_op(FUNC_PUSH, $urandom);
    write_register(REG_SPARE_A, CFG_W'($urandom));
    write_register(REG_SPARE_B, '1);
    send_op(FUNC_POP, $urandom);
    send_op(FUNC_POP, $urandom);
  endtask

  // fill a mid-size ring to the brim and hit full
  task automatic test_full_depth();
    set_idling(0);
    write_register(REG_ORDER_MODE, {10'h000, FIFO});
    write_register(REG_CAPACITY, 11'd64);
    repeat (65) send_op(FUNC_PUSH, $urandom);
    set_idling(3);
    send_random(24, 30);
  endtask

  task automatic test_random_settings();
    logic [CFG_W-1:0] cap_val;
    int push_pct;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cap_val = 11'd1;
        1: cap_val = 11'd2;
        2: cap_val = 11'd3;
        3: cap_val = 11'd0;
        4: cap_val = CFG_W'($urandom_range(4, 16));
        5: cap_val = CFG_W'($urandom_range(17, 1023));
        6: cap_val = 11'd2047;
        default: cap_val = 11'd1024;
      endcase
      push_pct = (p >= 5) ? 70 : $urandom_range(35, 65);
      write_register(REG_ORDER_MODE, {10'($urandom), p[0]});
      write_register(REG_CAPACITY, cap_val);
      set_idling(p);
      send_random(18, push_pct);
      // let the buffer settle completely before the second half
      if (p == 5) drain_results();
      set_idling(p + 1);
      send_random(18, (p >= 5) ? 40 : push_pct);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    func       <= FUNC_PUSH;
    push_value <= '0;
    out_ready  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_ORDER_MODE;
    cfg_data   <= '0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < SLOTS; i++) slot_mem[i] = '0;
    wr_pos = 0;
    rd_pos = 0;
    held_count = 0;
    order_sel = FIFO;
    cap_reg = CAPACITY_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_fifo_extremes();
    test_capacity_zero();
    test_stack_order();
    test_spare_index();
    test_full_depth();
    test_random_settings();

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) flag_mismatch("missing results", 0, 0);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/dmflb_pkg.sv
rtl/dmflb_mem.sv
rtl/dmflb_ctrl.sv
rtl/dmflb_outq.sv
rtl/dual_mode_fifo_lifo_buffer.sv
verif/dual_mode_fifo_lifo_buffer_test.sv
